>>> hw/rtl/hhnq_pkg.sv
// ----------------------------------------------------------------------------
// hhnq_pkg: shared types and constants
// Item modes, register indexes, the front-to-back item and the result item.
// ----------------------------------------------------------------------------
package hhnq_pkg;

	localparam int BLOCK_SIZE_DEF = 256;
	localparam int FRAC_BITS_DEF  = 8;
	localparam int CELL_MAX_W     = 10;
	localparam int MID_DEPTH      = 4;
	localparam int OUT_DEPTH      = 2;

	localparam logic [7:0] SQUARE_SIZE_RST = 8'd8;

	typedef enum logic [1:0] {
		MODE_HEIGHT = 2'd0,
		MODE_FLAGS  = 2'd1,
		MODE_QUERY  = 2'd2,
		MODE_NONE   = 2'd3
	} mode_t;

	typedef enum logic [0:0] {
		REG_SQUARE_SIZE = 1'b0,
		REG_TILING_ON   = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		mode_t                 mode;
		logic [15:0]           hv;
		logic                  emp;
		logic                  spl;
		logic                  ok;
		logic [CELL_MAX_W-1:0] cx;
		logic [CELL_MAX_W-1:0] cy;
		logic [7:0]            fx;
		logic [7:0]            fy;
	} mid_item_t;

	typedef struct packed {
		logic               hit;
		logic [23:0]        height;
		logic signed [16:0] nx;
		logic signed [16:0] ny;
	} out_item_t;

endpackage

>>> hw/rtl/hhnq_fifo.sv
// ----------------------------------------------------------------------------
// hhnq_fifo: small register queue
// Push/full in, pop/empty out; head entry shown while not empty.
// ----------------------------------------------------------------------------
module hhnq_fifo import hhnq_pkg::*; #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  logic [WIDTH-1:0] din,
	input  logic             pop,
	output logic             empty,
	output logic [WIDTH-1:0] dout
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [0:DEPTH-1];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CNW-1:0]   cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (cnt_q == CNW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			if (do_push && !do_pop)
				cnt_q <= cnt_q + CNW'(1);
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - CNW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= din;
	end

endmodule

>>> hw/rtl/hhnq_front.sv
// ----------------------------------------------------------------------------
// hhnq_front: accept and classify
// Pipelined floor divide of the query position, cell range check and
// wrap of the cell index (BLOCK_SIZE is a power of two); writes pass their
// cell through the same wrap.
// ----------------------------------------------------------------------------
module hhnq_front import hhnq_pkg::*; #(
	parameter int BLOCK_SIZE = BLOCK_SIZE_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  mode_t              mode,
	input  logic [7:0]         cell_x,
	input  logic [7:0]         cell_y,
	input  logic [15:0]        height_value,
	input  logic               empty_bit,
	input  logic               split_bit,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic [7:0]         square_size,
	input  logic               tiling_on,
	input  logic               mid_full,
	output logic               mid_push,
	output mid_item_t          mid_item
);

	localparam int SHL = (FRAC_BITS < 8) ? 8 - FRAC_BITS : 0;
	localparam int SHR = (FRAC_BITS > 8) ? FRAC_BITS - 8 : 0;
	localparam int NW  = 32 + SHL;
	localparam int UW  = NW - 1;
	localparam int CW  = NW - 8;
	localparam int CLW = $clog2(BLOCK_SIZE);

	typedef struct packed {
		mode_t       mode;
		logic [7:0]  cx;
		logic [7:0]  cy;
		logic [15:0] hv;
		logic        emp;
		logic        spl;
	} pay_t;

	function automatic logic [8:0] div_step(input logic [7:0] r, input logic b,
			input logic [7:0] d);
		logic [8:0] t;
		t = {r, b};
		if (t >= {1'b0, d})
			return {1'b1, 8'(t - {1'b0, d})};
		return {1'b0, t[7:0]};
	endfunction

	logic              en;
	logic [7:0]        dsor;
	pay_t              pay_in;
	logic signed [NW-1:0] n_x, n_y;
	logic [UW-1:0]     u_x, u_y;

	// divide stages
	logic          dv_s  [0:UW];
	pay_t          dp_s  [0:UW];
	logic          dnx_s [0:UW];
	logic          dny_s [0:UW];
	logic [UW-1:0] dax_s [0:UW];
	logic [UW-1:0] day_s [0:UW];
	logic [7:0]    drx_s [0:UW];
	logic [7:0]    dry_s [0:UW];
	logic [8:0]    stx [0:UW-1];
	logic [8:0]    sty [0:UW-1];

	// cell select
	logic [NW-1:0] qx, qy;
	logic [CW-1:0] ccx, ccy;
	logic          is_q, okx, oky;

	logic           fv_s;
	mid_item_t      fi_s;

	assign en       = !fv_s || !mid_full;
	assign full     = !en;
	assign mid_push = fv_s && !mid_full;
	assign mid_item = fi_s;
	assign dsor     = (square_size == 8'd0) ? 8'd1 : square_size;

	assign pay_in = '{mode: mode, cx: cell_x, cy: cell_y, hv: height_value,
		emp: empty_bit, spl: split_bit};

	assign n_x = (NW'(pos_x) <<< SHL) >>> SHR;
	assign n_y = (NW'(pos_y) <<< SHL) >>> SHR;
	assign u_x = n_x[NW-1] ? ~n_x[UW-1:0] : n_x[UW-1:0];
	assign u_y = n_y[NW-1] ? ~n_y[UW-1:0] : n_y[UW-1:0];

	for (genvar i = 0; i < UW; i++) begin : g_div
		assign stx[i] = div_step(drx_s[i], dax_s[i][UW-1], dsor);
		assign sty[i] = div_step(dry_s[i], day_s[i][UW-1], dsor);
	end

	assign qx   = dnx_s[UW] ? ~{1'b0, dax_s[UW]} : {1'b0, dax_s[UW]};
	assign qy   = dny_s[UW] ? ~{1'b0, day_s[UW]} : {1'b0, day_s[UW]};
	assign is_q = (dp_s[UW].mode == MODE_QUERY);
	assign ccx  = is_q ? qx[NW-1:8] : CW'(dp_s[UW].cx);
	assign ccy  = is_q ? qy[NW-1:8] : CW'(dp_s[UW].cy);
	assign okx  = !is_q || tiling_on ||
		(!ccx[CW-1] && (ccx[CW-2:0] < (CW-1)'(BLOCK_SIZE)));
	assign oky  = !is_q || tiling_on ||
		(!ccy[CW-1] && (ccy[CW-2:0] < (CW-1)'(BLOCK_SIZE)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= UW; i++)
				dv_s[i] <= 1'b0;
			fv_s <= 1'b0;
		end else if (en) begin
			dv_s[0] <= push;
			for (int i = 0; i < UW; i++)
				dv_s[i+1] <= dv_s[i];
			fv_s <= dv_s[UW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dp_s[0]  <= pay_in;
			dnx_s[0] <= n_x[NW-1];
			dny_s[0] <= n_y[NW-1];
			dax_s[0] <= u_x;
			day_s[0] <= u_y;
			drx_s[0] <= '0;
			dry_s[0] <= '0;
			for (int i = 0; i < UW; i++) begin
				dp_s[i+1]  <= dp_s[i];
				dnx_s[i+1] <= dnx_s[i];
				dny_s[i+1] <= dny_s[i];
				dax_s[i+1] <= {dax_s[i][UW-2:0], stx[i][8]};
				day_s[i+1] <= {day_s[i][UW-2:0], sty[i][8]};
				drx_s[i+1] <= stx[i][7:0];
				dry_s[i+1] <= sty[i][7:0];
			end

			// two's complement low bits give the cell modulo BLOCK_SIZE
			fi_s.mode <= dp_s[UW].mode;
			fi_s.hv   <= dp_s[UW].hv;
			fi_s.emp  <= dp_s[UW].emp;
			fi_s.spl  <= dp_s[UW].spl;
			fi_s.ok   <= okx && oky;
			fi_s.cx   <= CELL_MAX_W'(ccx[CLW-1:0]);
			fi_s.cy   <= CELL_MAX_W'(ccy[CLW-1:0]);
			fi_s.fx   <= qx[7:0];
			fi_s.fy   <= qy[7:0];
		end
	end

endmodule

>>> hw/rtl/hhnq_back.sv
// ----------------------------------------------------------------------------
// hhnq_back: store access and interpolation
// Height and flag stores, corner fetch, triangle select and the
// interpolated height and normal differences.
// ----------------------------------------------------------------------------
module hhnq_back import hhnq_pkg::*; #(
	parameter int BLOCK_SIZE = BLOCK_SIZE_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      mid_empty,
	output logic      mid_pop,
	input  mid_item_t mid_item,
	input  logic      out_full,
	output logic      out_push,
	output out_item_t out_item
);

	localparam int CLW   = $clog2(BLOCK_SIZE);
	localparam int DEPTH = BLOCK_SIZE * BLOCK_SIZE;
	localparam int AW    = $clog2(DEPTH);

	function automatic logic [AW-1:0] addr_of(input logic [CLW-1:0] x,
			input logic [CLW-1:0] y);
		return AW'(AW'(y) * AW'(BLOCK_SIZE) + AW'(x));
	endfunction

	function automatic logic signed [16:0] dif(input logic [15:0] a, input logic [15:0] b);
		return $signed({1'b0, a}) - $signed({1'b0, b});
	endfunction

	logic [15:0] hmem_a [0:DEPTH-1];
	logic [15:0] hmem_b [0:DEPTH-1];
	logic [1:0]  fmem   [0:DEPTH-1];

	logic           en;
	logic [CLW-1:0] cx, cy, cx1, cy1;
	logic [AW-1:0]  a00, a10, a01, a11;

	logic        v_s1, ok_s1;
	mode_t       mode_s1;
	logic [7:0]  fx_s1, fy_s1;
	logic [15:0] bl_s1, br_s1, tl_s1, tr_s1;
	logic [1:0]  fl_s1;

	logic               hit_c;
	logic [15:0]        base_c;
	logic [8:0]         a_c;
	logic signed [16:0] d1_c, d2_c, nx_c, ny_c;
	logic [8:0]         fsum;

	logic               v_s2, hit_s2;
	logic [15:0]        base_s2;
	logic [8:0]         a_s2;
	logic [7:0]         b_s2;
	logic signed [16:0] d1_s2, d2_s2, nx_s2, ny_s2;

	logic               v_s3, hit_s3;
	logic [15:0]        base_s3;
	logic signed [26:0] p1_s3;
	logic signed [25:0] p2_s3;
	logic signed [16:0] nx_s3, ny_s3;

	logic signed [27:0] sum;
	logic               v_s4;
	out_item_t          o_s4;

	assign en       = !v_s4 || !out_full;
	assign mid_pop  = en && !mid_empty;
	assign out_push = v_s4 && !out_full;
	assign out_item = o_s4;

	assign cx  = mid_item.cx[CLW-1:0];
	assign cy  = mid_item.cy[CLW-1:0];
	assign cx1 = (cx == CLW'(BLOCK_SIZE - 1)) ? '0 : cx + CLW'(1);
	assign cy1 = (cy == CLW'(BLOCK_SIZE - 1)) ? '0 : cy + CLW'(1);
	assign a00 = addr_of(cx, cy);
	assign a10 = addr_of(cx1, cy);
	assign a01 = addr_of(cx, cy1);
	assign a11 = addr_of(cx1, cy1);

	always_ff @(posedge clk) begin
		if (mid_pop) begin
			if (mid_item.mode == MODE_HEIGHT) begin
				hmem_a[a00] <= mid_item.hv;
				hmem_b[a00] <= mid_item.hv;
			end
			if (mid_item.mode == MODE_FLAGS)
				fmem[a00] <= {mid_item.spl, mid_item.emp};
		end
		if (en) begin
			bl_s1   <= hmem_a[a00];
			br_s1   <= hmem_a[a10];
			tl_s1   <= hmem_b[a01];
			tr_s1   <= hmem_b[a11];
			fl_s1   <= fmem[a00];
			mode_s1 <= mid_item.mode;
			ok_s1   <= mid_item.ok;
			fx_s1   <= mid_item.fx;
			fy_s1   <= mid_item.fy;
		end
	end

	assign fsum = {1'b0, fx_s1} + {1'b0, fy_s1};

	always_comb begin
		hit_c = (mode_s1 == MODE_QUERY) && ok_s1 && !fl_s1[0];
		priority if (fl_s1[1] && (fx_s1 > fy_s1)) begin
			base_c = bl_s1; a_c = {1'b0, fx_s1};
			d1_c = dif(br_s1, bl_s1); d2_c = dif(tr_s1, br_s1);
			nx_c = dif(bl_s1, br_s1); ny_c = dif(br_s1, tr_s1);
		end else if (fl_s1[1]) begin
			base_c = bl_s1; a_c = {1'b0, fx_s1};
			d1_c = dif(tr_s1, tl_s1); d2_c = dif(tl_s1, bl_s1);
			nx_c = dif(tl_s1, tr_s1); ny_c = dif(bl_s1, tl_s1);
		end else if (fsum < 9'd256) begin
			base_c = br_s1; a_c = 9'd256 - {1'b0, fx_s1};
			d1_c = dif(bl_s1, br_s1); d2_c = dif(tl_s1, bl_s1);
			nx_c = dif(bl_s1, br_s1); ny_c = dif(bl_s1, tl_s1);
		end else begin
			base_c = br_s1; a_c = 9'd256 - {1'b0, fx_s1};
			d1_c = dif(tl_s1, tr_s1); d2_c = dif(tr_s1, br_s1);
			nx_c = dif(tl_s1, tr_s1); ny_c = dif(br_s1, tr_s1);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit_s2  <= hit_c;
			base_s2 <= base_c;
			a_s2    <= a_c;
			b_s2    <= fy_s1;
			d1_s2   <= d1_c;
			d2_s2   <= d2_c;
			nx_s2   <= nx_c;
			ny_s2   <= ny_c;

			hit_s3  <= hit_s2;
			base_s3 <= base_s2;
			p1_s3   <= 27'($signed({1'b0, a_s2})) * 27'(d1_s2);
			p2_s3   <= 26'($signed({1'b0, b_s2})) * 26'(d2_s2);
			nx_s3   <= nx_s2;
			ny_s3   <= ny_s2;

			o_s4.hit    <= hit_s3;
			o_s4.height <= hit_s3 ? sum[23:0] : '0;
			o_s4.nx     <= hit_s3 ? nx_s3 : '0;
			o_s4.ny     <= hit_s3 ? ny_s3 : '0;
		end
	end

	assign sum = 28'($signed({1'b0, base_s3, 8'd0})) + 28'(p1_s3) + 28'(p2_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= !mid_empty;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

endmodule

>>> hw/rtl/heightfield_height_normal_query.sv
// ----------------------------------------------------------------------------
// heightfield_height_normal_query: height map store and triangle query
// Height and cell flag writes, and position queries that return the
// interpolated height and the unnormalized normal differences.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue: drive an item and push; it is taken when full is low.
//   Mode 0 writes a height sample, mode 1 a cell's flags, mode 2 queries.
//   Every transaction yields exactly one result, in order.
//   Result queue: the oldest result is shown while empty is low and is
//   removed by pop. Writes and misses return hit low with zero fields.
//   Config: cfg_we writes square_size (index 0) or tiling_on (index 1);
//   write only while no transaction is in flight.
//   Throughput: one transaction per cycle, sustained while results are popped.
//   Path from push to empty low at BLOCK_SIZE 256 and FRAC_BITS 8: the front
//   divide takes one quotient bit per stage (31 stages), then the cell wrap,
//   the middle queue, store read and arithmetic.
//   A stalled receiver fills the result queue, then the back pipeline and
//   the middle queue, and full rises once the front has nowhere to go.
//   Reset clears all queues and pipelines; the stores hold no defined value
//   until written.
// ----------------------------------------------------------------------------
module heightfield_height_normal_query import hhnq_pkg::*; #(
	parameter int BLOCK_SIZE = BLOCK_SIZE_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  mode_t              mode,
	input  logic [7:0]         cell_x,
	input  logic [7:0]         cell_y,
	input  logic [15:0]        height_value,
	input  logic               empty_bit,
	input  logic               split_bit,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	output logic               empty,
	input  logic               pop,
	output logic               hit,
	output logic [23:0]        height_out,
	output logic signed [16:0] normal_x,
	output logic signed [16:0] normal_y,
	input  logic               cfg_we,
	input  logic [0:0]         cfg_index,
	input  logic [7:0]         cfg_data
);

	logic [7:0] size_q;
	logic       tiling_q;

	logic      mid_push, mid_full, mid_empty, mid_pop;
	mid_item_t mid_in, mid_head;
	logic [$bits(mid_item_t)-1:0] mid_dout;

	logic      out_push, out_full;
	out_item_t out_in, out_head;
	logic [$bits(out_item_t)-1:0] out_dout;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q   <= SQUARE_SIZE_RST;
			tiling_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_SQUARE_SIZE: size_q   <= cfg_data;
				REG_TILING_ON:   tiling_q <= cfg_data[0];
			endcase
		end
	end

	hhnq_front #(
		.BLOCK_SIZE (BLOCK_SIZE),
		.FRAC_BITS  (FRAC_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.mode         (mode),
		.cell_x       (cell_x),
		.cell_y       (cell_y),
		.height_value (height_value),
		.empty_bit    (empty_bit),
		.split_bit    (split_bit),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.square_size  (size_q),
		.tiling_on    (tiling_q),
		.mid_full     (mid_full),
		.mid_push     (mid_push),
		.mid_item     (mid_in)
	);

	hhnq_fifo #(
		.WIDTH ($bits(mid_item_t)),
		.DEPTH (MID_DEPTH)
	) u_mid_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (mid_push),
		.full   (mid_full),
		.din    (mid_in),
		.pop    (mid_pop),
		.empty  (mid_empty),
		.dout   (mid_dout)
	);

	assign mid_head = mid_item_t'(mid_dout);

	hhnq_back #(
		.BLOCK_SIZE (BLOCK_SIZE)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.mid_empty (mid_empty),
		.mid_pop   (mid_pop),
		.mid_item  (mid_head),
		.out_full  (out_full),
		.out_push  (out_push),
		.out_item  (out_in)
	);

	hhnq_fifo #(
		.WIDTH ($bits(out_item_t)),
		.DEPTH (OUT_DEPTH)
	) u_out_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (out_push),
		.full   (out_full),
		.din    (out_in),
		.pop    (pop),
		.empty  (empty),
		.dout   (out_dout)
	);

	assign out_head   = out_item_t'(out_dout);
	assign hit        = out_head.hit;
	assign height_out = out_head.height;
	assign normal_x   = out_head.nx;
	assign normal_y   = out_head.ny;

`ifndef NO_ASSERTIONS
	a_mid_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		mid_push |-> !mid_full) else $error("middle queue overflow");

	a_out_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		out_push |-> !out_full) else $error("result queue overflow");

	a_full_only_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> mid_full) else $error("input blocked with room downstream");

	a_pop_moves_back: assert property (@(posedge clk) disable iff (!arst_n)
		mid_pop |=> $past(!mid_empty)) else $error("pop from empty middle queue");
`endif

endmodule
